>>> rtl/sbpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpe_pkg
// shared types and constants of the servo bus packet engine
// ----------------------------------------------------------------------------
package sbpe_pkg;

	// item opcodes
	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// result kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	// outcome status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_ERROR   = 2'd1;
	localparam logic [1:0] STATUS_NO_RESP = 2'd2;

	localparam logic [7:0] START_BYTE     = 8'hFF;
	localparam logic [7:0] BCAST_SERVO_ID = 8'd254;

	// byte positions within an instruction packet
	localparam logic [3:0] POS_START0 = 4'd0;
	localparam logic [3:0] POS_START1 = 4'd1;
	localparam logic [3:0] POS_ID     = 4'd2;
	localparam logic [3:0] POS_LEN    = 4'd3;
	localparam logic [3:0] POS_INSTR  = 4'd4;
	localparam logic [3:0] POS_PARAM0 = 4'd5;

	localparam int PARAM_SLOTS     = 6;
	localparam int MAX_PARAMS_DEF  = 6;
	localparam int JOB_DEPTH_DEF   = 4;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10;

	// config register index (byte address / 4)
	localparam logic REG_TIMEOUT = 1'b0;

	// one unit of work for the back end: a whole packet or one outcome
	typedef struct packed {
		logic        is_pkt;
		logic [7:0]  servo_id;
		logic [7:0]  instruction;
		logic [2:0]  pcount;
		logic [47:0] params;
		logic [7:0]  chksum;
		logic [1:0]  status;
		logic [7:0]  error_flags;
		logic [15:0] reply_value;
	} job_t;

endpackage

>>> rtl/sbpe_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpe_cmd_if
// input item channel: command, received line byte or timeout tick
// ----------------------------------------------------------------------------
interface sbpe_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  servo_id;
	logic [7:0]  instruction;
	logic [2:0]  param_count;
	logic [47:0] param_bytes;
	logic [1:0]  reply_data_count;
	logic [7:0]  line_byte;

	modport source (
		output valid, opcode, servo_id, instruction, param_count, param_bytes,
		       reply_data_count, line_byte,
		input  ready
	);
	modport sink (
		input  valid, opcode, servo_id, instruction, param_count, param_bytes,
		       reply_data_count, line_byte,
		output ready
	);
endinterface

>>> rtl/sbpe_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpe_res_if
// result item channel: packet byte or reply outcome
// ----------------------------------------------------------------------------
interface sbpe_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  send_byte;
	logic        last;
	logic [1:0]  status;
	logic [7:0]  error_flags;
	logic [15:0] reply_value;

	modport source (
		output valid, kind, send_byte, last, status, error_flags, reply_value,
		input  ready
	);
	modport sink (
		input  valid, kind, send_byte, last, status, error_flags, reply_value,
		output ready
	);
endinterface

>>> rtl/servo_bus_packet_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_packet_engine_core
// half-duplex servo bus packet engine: frames instruction packets and parses
// the status reply
// ----------------------------------------------------------------------------
// the engine takes one item per cycle on cmd: a send command, a received bus
// byte or a timeout tick. a send command comes out on res as its packet bytes
// (ff, ff, id, length, instruction, params, inverted-sum checksum, the last one
// marked), one item per cycle while res is ready, so a command with n params
// gives n+6 result items; bytes and ticks produce at most one outcome item (ok,
// servo error, no response). the front end decides everything at accept time
// and queues jobs in a four-entry queue, so cmd keeps flowing while the back
// end is still serializing a packet; cmd stalls only when that queue is full.
// sustained rate is set by the back end's one-result-per-cycle output register
// while res is ready. the user must write the reply timeout over the apb-style
// port at byte address 0 only while the engine is idle; the block does not check.
// ----------------------------------------------------------------------------
module servo_bus_packet_engine_core #(
	parameter int MAX_PARAMS = sbpe_pkg::MAX_PARAMS_DEF,
	parameter int JOB_DEPTH  = sbpe_pkg::JOB_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sbpe_cmd_if.sink    cmd,
	sbpe_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// reply timeout register
	logic [15:0] timeout_q;
	logic        reg_hit;

	// job path between front and back end
	logic           job_valid, job_full, head_valid, pop;
	sbpe_pkg::job_t job, head_job;

	// register index is the word address bit
	assign reg_hit = (paddr[2] == sbpe_pkg::REG_TIMEOUT);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbpe_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// front: accepts items, frames commands, tracks the reply parse
	sbpe_front #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.timeout_ticks (timeout_q),
		.job_ready     (!job_full),
		.job_valid     (job_valid),
		.job           (job)
	);

	// short queue decoupling the two sides
	sbpe_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.full       (job_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// back: turns each job into result items
	sbpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.res        (res)
	);

endmodule

>>> rtl/sbpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpe_front
// accepts items, frames commands, parses the status reply, issues jobs
// ----------------------------------------------------------------------------
module sbpe_front #(
	parameter int MAX_PARAMS = sbpe_pkg::MAX_PARAMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	sbpe_cmd_if.sink         cmd,
	input  logic [15:0]      timeout_ticks,
	input  logic             job_ready,
	output logic             job_valid,
	output sbpe_pkg::job_t   job
);

	localparam int CAP = (MAX_PARAMS < sbpe_pkg::PARAM_SLOTS) ? MAX_PARAMS
	                                                          : sbpe_pkg::PARAM_SLOTS;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'b01,
		MODE_WAIT = 2'b10
	} mode_t;

	typedef enum logic [6:0] {
		PH_HUNT1 = 7'b0000001,
		PH_HUNT2 = 7'b0000010,
		PH_ID    = 7'b0000100,
		PH_LEN   = 7'b0001000,
		PH_ERR   = 7'b0010000,
		PH_LOW   = 7'b0100000,
		PH_HIGH  = 7'b1000000
	} phase_t;

	mode_t       mode_q, mode_d;
	phase_t      phase_q, phase_d;
	logic [15:0] wait_q, wait_d, wait_inc;
	logic [1:0]  expect_q, expect_d;
	logic [7:0]  low_q, low_d;

	logic        acc;
	logic [2:0]  n_cap;
	logic [7:0]  sum;
	logic [7:0]  len_byte;

	assign cmd.ready = job_ready;
	assign acc       = cmd.valid && cmd.ready;

	// parameter count saturates at the carried slots
	assign n_cap    = (cmd.param_count > 3'(CAP)) ? 3'(CAP) : cmd.param_count;
	assign len_byte = {5'd0, n_cap} + 8'd2;

	always_comb begin
		sum = cmd.servo_id + len_byte + cmd.instruction;
		for (int i = 0; i < sbpe_pkg::PARAM_SLOTS; i++) begin
			if (3'(i) < n_cap) begin
				sum = sum + cmd.param_bytes[i*8 +: 8];
			end
		end
	end

	assign wait_inc = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

	always_comb begin
		mode_d    = mode_q;
		phase_d   = phase_q;
		wait_d    = wait_q;
		expect_d  = expect_q;
		low_d     = low_q;
		job_valid = 1'b0;
		job              = '0;
		job.servo_id     = cmd.servo_id;
		job.instruction  = cmd.instruction;
		job.pcount       = n_cap;
		job.params       = cmd.param_bytes;
		job.chksum       = ~sum;

		if (acc) begin
			if (cmd.opcode == sbpe_pkg::OP_SEND) begin
				job.is_pkt = 1'b1;
				job_valid  = 1'b1;
				phase_d    = PH_HUNT1;
				wait_d     = '0;
				low_d      = '0;
				expect_d   = (cmd.reply_data_count == 2'd3) ? 2'd2 : cmd.reply_data_count;
				mode_d     = (cmd.servo_id == sbpe_pkg::BCAST_SERVO_ID) ? MODE_IDLE : MODE_WAIT;
			end else if (mode_q == MODE_WAIT && cmd.opcode == sbpe_pkg::OP_BYTE) begin
				case (phase_q)
					PH_HUNT1: begin
						if (cmd.line_byte == sbpe_pkg::START_BYTE) phase_d = PH_HUNT2;
					end
					PH_HUNT2: begin
						phase_d = (cmd.line_byte == sbpe_pkg::START_BYTE) ? PH_ID : PH_HUNT1;
					end
					PH_ID:  phase_d = PH_LEN;
					PH_LEN: phase_d = PH_ERR;
					PH_ERR: begin
						if (cmd.line_byte != 8'd0) begin
							job_valid       = 1'b1;
							job.status      = sbpe_pkg::STATUS_ERROR;
							job.error_flags = cmd.line_byte;
						end else if (expect_q == 2'd0) begin
							job_valid  = 1'b1;
							job.status = sbpe_pkg::STATUS_OK;
						end else begin
							phase_d = PH_LOW;
						end
					end
					PH_LOW: begin
						if (expect_q == 2'd1) begin
							job_valid       = 1'b1;
							job.status      = sbpe_pkg::STATUS_OK;
							job.reply_value = {8'd0, cmd.line_byte};
						end else begin
							low_d   = cmd.line_byte;
							phase_d = PH_HIGH;
						end
					end
					PH_HIGH: begin
						job_valid       = 1'b1;
						job.status      = sbpe_pkg::STATUS_OK;
						job.reply_value = {cmd.line_byte, low_q};
					end
					default: phase_d = PH_HUNT1;
				endcase
			end else if (mode_q == MODE_WAIT && cmd.opcode == sbpe_pkg::OP_TICK) begin
				wait_d = wait_inc;
				if (wait_inc >= timeout_ticks) begin
					job_valid  = 1'b1;
					job.status = sbpe_pkg::STATUS_NO_RESP;
				end
			end

			// any outcome closes the reply
			if (job_valid && !job.is_pkt) begin
				mode_d  = MODE_IDLE;
				phase_d = PH_HUNT1;
				wait_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			phase_q  <= PH_HUNT1;
			wait_q   <= '0;
			expect_q <= '0;
			low_q    <= '0;
		end else begin
			mode_q   <= mode_d;
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			expect_q <= expect_d;
			low_q    <= low_d;
		end
	end

endmodule

>>> rtl/sbpe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpe_fifo
// short job queue between front and back end
// ----------------------------------------------------------------------------
module sbpe_fifo #(
	parameter int DEPTH = sbpe_pkg::JOB_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbpe_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output sbpe_pkg::job_t head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sbpe_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/sbpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpe_back
// serializes jobs into result items through an output register
// ----------------------------------------------------------------------------
module sbpe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sbpe_pkg::job_t head_job,
	output logic           pop,
	sbpe_res_if.source     res
);

	sbpe_pkg::job_t job_q;
	logic           job_valid_q;
	logic [3:0]     idx_q;

	logic           out_valid_q;
	logic           kind_q, last_q;
	logic [7:0]     byte_q, err_q;
	logic [1:0]     status_q;
	logic [15:0]    value_q;

	logic           out_free, adv, is_last;
	logic [3:0]     last_idx;
	logic [2:0]     pidx;
	logic [7:0]     pbyte, cur_byte;

	assign out_free = !out_valid_q || res.ready;
	assign adv      = job_valid_q && out_free;
	assign last_idx = sbpe_pkg::POS_PARAM0 + {1'b0, job_q.pcount};
	assign is_last  = !job_q.is_pkt || (idx_q == last_idx);
	assign pop      = head_valid && (!job_valid_q || (adv && is_last));

	assign pidx = 3'(idx_q - sbpe_pkg::POS_PARAM0);

	always_comb begin
		case (pidx)
			3'd0:    pbyte = job_q.params[7:0];
			3'd1:    pbyte = job_q.params[15:8];
			3'd2:    pbyte = job_q.params[23:16];
			3'd3:    pbyte = job_q.params[31:24];
			3'd4:    pbyte = job_q.params[39:32];
			3'd5:    pbyte = job_q.params[47:40];
			default: pbyte = 8'd0;
		endcase
	end

	always_comb begin
		case (idx_q)
			sbpe_pkg::POS_START0: cur_byte = sbpe_pkg::START_BYTE;
			sbpe_pkg::POS_START1: cur_byte = sbpe_pkg::START_BYTE;
			sbpe_pkg::POS_ID:     cur_byte = job_q.servo_id;
			sbpe_pkg::POS_LEN:    cur_byte = {5'd0, job_q.pcount} + 8'd2;
			sbpe_pkg::POS_INSTR:  cur_byte = job_q.instruction;
			default:              cur_byte = (idx_q == last_idx) ? job_q.chksum : pbyte;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= head_job;
		if (adv) begin
			kind_q   <= job_q.is_pkt ? sbpe_pkg::KIND_BYTE : sbpe_pkg::KIND_OUTCOME;
			byte_q   <= job_q.is_pkt ? cur_byte : 8'd0;
			last_q   <= is_last;
			status_q <= job_q.status;
			err_q    <= job_q.error_flags;
			value_q  <= job_q.reply_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (adv) begin
				if (is_last) job_valid_q <= 1'b0;
				idx_q <= idx_q + 4'd1;
			end
			if (out_free) out_valid_q <= adv;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = kind_q;
	assign res.send_byte   = byte_q;
	assign res.last        = last_q;
	assign res.status      = status_q;
	assign res.error_flags = err_q;
	assign res.reply_value = value_q;

endmodule

>>> test/servo_bus_packet_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_packet_engine_core_test
// self-checking bench: drives commands, bus bytes and ticks into the engine,
// predicts every packet byte and reply outcome, and checks them in order
// under random idling, a long output hold-off and several timeout settings
// ----------------------------------------------------------------------------
module servo_bus_packet_engine_core_test;

	// opcode with no meaning, must be dropped silently
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// params actually carried in a packet
	localparam int PARAM_CAP = (sbpe_pkg::MAX_PARAMS_DEF < sbpe_pkg::PARAM_SLOTS)
		? sbpe_pkg::MAX_PARAMS_DEF : sbpe_pkg::PARAM_SLOTS;
	// cycles to let the job queue and output register settle before a register write
	localparam int SETTLE_CYCLES = 16;
	// long output hold-off, long enough to fill the job queue and stall cmd
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_NS = 5_000_000;
	localparam int PRINT_CAP = 100;

	// reply parser position, mirrors the engine's hunt / header / data walk
	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_ID,
		PH_LEN,
		PH_ERR,
		PH_DATA_LO,
		PH_DATA_HI
	} reply_phase_t;

	typedef struct {
		logic [1:0]  opcode;
		logic [7:0]  servo_id;
		logic [7:0]  instruction;
		logic [2:0]  param_count;
		logic [47:0] param_bytes;
		logic [1:0]  reply_data_count;
		logic [7:0]  line_byte;
	} cmd_item_t;

	typedef struct {
		logic        kind;
		logic [7:0]  send_byte;
		logic        last;
		logic [1:0]  status;
		logic [7:0]  error_flags;
		logic [15:0] reply_value;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sbpe_cmd_if cmd();
	sbpe_res_if res();

	servo_bus_packet_engine_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted engine state, updated at the edge an item is accepted
	logic [15:0]  timeout_ticks_cfg;
	logic         awaiting_reply;
	reply_phase_t reply_phase;
	int unsigned  ticks_waited;
	logic [1:0]   reply_len;
	logic [7:0]   data_lo;

	// results still owed by the engine, oldest first
	bus_result_t pending_bus_results[$];

	int mismatch_count;
	int counted_items;
	int send_idle_pct;
	int stall_pct;
	int hold_left;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	function automatic void push_result(input logic kind, input logic [7:0] b,
			input logic last, input logic [1:0] st, input logic [7:0] err,
			input logic [15:0] val);
		bus_result_t r;
		r.kind        = kind;
		r.send_byte   = b;
		r.last        = last;
		r.status      = st;
		r.error_flags = err;
		r.reply_value = val;
		pending_bus_results.push_back(r);
	endfunction

	function automatic void push_packet_byte(input logic [7:0] b, input logic last);
		push_result(sbpe_pkg::KIND_BYTE, b, last, sbpe_pkg::STATUS_OK, 8'h00,
			16'h0000);
	endfunction

	// an outcome closes the exchange and puts the engine back to idle
	function automatic void push_outcome(input logic [1:0] st, input logic [7:0] err,
			input logic [15:0] val);
		push_result(sbpe_pkg::KIND_OUTCOME, 8'h00, 1'b1, st, err, val);
		awaiting_reply = 1'b0;
		reply_phase    = PH_HUNT0;
		ticks_waited   = 0;
	endfunction

	// works out the results one accepted item causes and advances the state
	function automatic void predict_engine_output(input cmd_item_t it);
		int         n;
		int         i;
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] pb;
		case (it.opcode)
			sbpe_pkg::OP_SEND: begin
				n   = (it.param_count > PARAM_CAP) ? PARAM_CAP : it.param_count;
				len = 8'(n + 2);
				push_packet_byte(sbpe_pkg::START_BYTE, 1'b0);
				push_packet_byte(sbpe_pkg::START_BYTE, 1'b0);
				push_packet_byte(it.servo_id, 1'b0);
				push_packet_byte(len, 1'b0);
				push_packet_byte(it.instruction, 1'b0);
				sum = it.servo_id + len + it.instruction;
				for (i = 0; i < n; i++) begin
					pb  = it.param_bytes[8*i +: 8];
					sum = sum + pb;
					push_packet_byte(pb, 1'b0);
				end
				push_packet_byte(~sum, 1'b1);
				// a new command drops whatever reply was pending
				reply_phase    = PH_HUNT0;
				ticks_waited   = 0;
				data_lo        = 8'h00;
				reply_len      = (it.reply_data_count > 2'd2) ? 2'd2 : it.reply_data_count;
				awaiting_reply = (it.servo_id != sbpe_pkg::BCAST_SERVO_ID);
			end
			sbpe_pkg::OP_BYTE: begin
				if (awaiting_reply) begin
					case (reply_phase)
						PH_HUNT0:
							if (it.line_byte == sbpe_pkg::START_BYTE)
								reply_phase = PH_HUNT1;
						PH_HUNT1:
							reply_phase = (it.line_byte == sbpe_pkg::START_BYTE)
								? PH_ID : PH_HUNT0;
						PH_ID:
							reply_phase = PH_LEN;
						PH_LEN:
							reply_phase = PH_ERR;
						PH_ERR: begin
							if (it.line_byte != 8'h00)
								push_outcome(sbpe_pkg::STATUS_ERROR, it.line_byte, 16'h0000);
							else if (reply_len == 2'd0)
								push_outcome(sbpe_pkg::STATUS_OK, 8'h00, 16'h0000);
							else
								reply_phase = PH_DATA_LO;
						end
						PH_DATA_LO: begin
							if (reply_len == 2'd1) begin
								push_outcome(sbpe_pkg::STATUS_OK, 8'h00, {8'h00, it.line_byte});
							end else begin
								data_lo     = it.line_byte;
								reply_phase = PH_DATA_HI;
							end
						end
						PH_DATA_HI:
							push_outcome(sbpe_pkg::STATUS_OK, 8'h00, {it.line_byte, data_lo});
						default:
							reply_phase = PH_HUNT0;
					endcase
				end
			end
			sbpe_pkg::OP_TICK: begin
				if (awaiting_reply) begin
					if (ticks_waited < 32'hFFFF)
						ticks_waited++;
					if (ticks_waited >= timeout_ticks_cfg)
						push_outcome(sbpe_pkg::STATUS_NO_RESP, 8'h00, 16'h0000);
				end
			end
			default: ;
		endcase
	endfunction

	// unused fields carry random values so the engine is seen to ignore them
	function automatic cmd_item_t random_fields();
		cmd_item_t it;
		it.opcode           = 2'($urandom_range(3));
		it.servo_id         = 8'($urandom_range(254));
		it.instruction      = 8'($urandom);
		it.param_count      = 3'($urandom);
		it.param_bytes      = {16'($urandom), 32'($urandom)};
		it.reply_data_count = 2'($urandom);
		it.line_byte        = 8'($urandom);
		return it;
	endfunction

	function automatic cmd_item_t make_cmd(input logic [7:0] id, input logic [7:0] ins,
			input logic [2:0] n, input logic [47:0] pb, input logic [1:0] rc);
		cmd_item_t it;
		it                  = random_fields();
		it.opcode           = sbpe_pkg::OP_SEND;
		it.servo_id         = id;
		it.instruction      = ins;
		it.param_count      = n;
		it.param_bytes      = pb;
		it.reply_data_count = rc;
		return it;
	endfunction

	function automatic cmd_item_t make_op(input logic [1:0] op, input logic [7:0] b);
		cmd_item_t it;
		it           = random_fields();
		it.opcode    = op;
		it.line_byte = b;
		return it;
	endfunction

	function automatic cmd_item_t random_cmd();
		logic [7:0] id;
		id = ($urandom_range(7) == 0) ? sbpe_pkg::BCAST_SERVO_ID
			: 8'($urandom_range(253));
		return make_cmd(id, 8'($urandom), 3'($urandom), {16'($urandom), 32'($urandom)},
			2'($urandom));
	endfunction

	// offers one item, idling first at the current rate, and predicts on accept
	task automatic send_item(input cmd_item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid            <= 1'b1;
		cmd.opcode           <= it.opcode;
		cmd.servo_id         <= it.servo_id;
		cmd.instruction      <= it.instruction;
		cmd.param_count      <= it.param_count;
		cmd.param_bytes      <= it.param_bytes;
		cmd.reply_data_count <= it.reply_data_count;
		cmd.line_byte        <= it.line_byte;
		do
			@(posedge clk);
		while (!cmd.ready);
		counted_items++;
		predict_engine_output(it);
	endtask

	// sends bus bytes, first byte in the highest of the n used bytes of seq
	task automatic send_line_bytes(input int n, input logic [95:0] seq);
		int i;
		for (i = 0; i < n; i++)
			send_item(make_op(sbpe_pkg::OP_BYTE, seq[8*(n-1-i) +: 8]));
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_item(make_op(sbpe_pkg::OP_TICK, 8'($urandom)));
	endtask

	// sender pauses until every owed result is out, then lets the back end settle
	task automatic wait_all_results();
		cmd.valid <= 1'b0;
		while (pending_bus_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// one apb transfer: setup cycle, then access until pready
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sbpe_pkg::REG_TIMEOUT, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] ticks);
		logic [31:0] rd;
		wait_all_results();
		apb_access(1'b1, {16'h0000, ticks}, rd);
		timeout_ticks_cfg = ticks;
		apb_access(1'b0, 32'h0000_0000, rd);
		check_field("timeout readback", rd[15:0], ticks);
	endtask

	// one command and a plausible bus reaction: clean reply, timeout, or nothing
	task automatic random_exchange();
		cmd_item_t  c;
		int         choice;
		int         n;
		logic [7:0] err;
		c = random_cmd();
		send_item(c);
		if (c.servo_id == sbpe_pkg::BCAST_SERVO_ID) begin
			// stray byte after a broadcast, engine is idle
			if ($urandom_range(1) == 1)
				send_item(make_op(sbpe_pkg::OP_BYTE, sbpe_pkg::START_BYTE));
			return;
		end
		choice = $urandom_range(9);
		if (choice <= 5) begin
			if ($urandom_range(3) == 0)
				send_line_bytes(1, 96'($urandom_range(254)));
			// lone start byte, hunt must restart
			if ($urandom_range(4) == 0)
				send_line_bytes(2, 96'({sbpe_pkg::START_BYTE, 8'($urandom_range(254))}));
			send_line_bytes(4, 96'({sbpe_pkg::START_BYTE, sbpe_pkg::START_BYTE,
				c.servo_id, 8'($urandom)}));
			if ($urandom_range(6) == 0)
				send_ticks(1);
			err = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
			send_line_bytes(1, 96'(err));
			n = (c.reply_data_count > 2'd2) ? 2 : c.reply_data_count;
			if (n > 0)
				send_line_bytes(n, 96'($urandom));
		end else if (choice <= 7) begin
			// partial header then silence
			if (choice == 7)
				send_line_bytes(3, 96'({sbpe_pkg::START_BYTE, sbpe_pkg::START_BYTE,
					c.servo_id}));
			n = (timeout_ticks_cfg > 16'd12) ? 12 : timeout_ticks_cfg;
			send_ticks((n == 0) ? 1 : n);
		end
		// otherwise leave the reply pending, the next command drops it
	endtask

	task automatic run_exchanges(input int n, input int sender_idle, input int receiver_stall);
		int target;
		send_idle_pct = sender_idle;
		stall_pct     = receiver_stall;
		target        = counted_items + n;
		while (counted_items < target)
			random_exchange();
	endtask

	// framing extremes, broadcast, and items the idle engine must ignore
	task automatic test_packet_framing();
		// saturated param count and reply count, all-ones fields
		send_item(make_cmd(8'd253, 8'hFF, 3'd7, 48'hFFFF_FFFF_FFFF, 2'd3));
		// broken hunt, then a full reply with two data bytes
		send_line_bytes(9, 96'({sbpe_pkg::START_BYTE, 8'h00, sbpe_pkg::START_BYTE,
			sbpe_pkg::START_BYTE, 8'd253, 8'h08, 8'h00, 8'h34, 8'h12}));
		// broadcast with zero fields, no reply awaited
		send_item(make_cmd(sbpe_pkg::BCAST_SERVO_ID, 8'h00, 3'd0, 48'h0, 2'd0));
		send_item(make_op(sbpe_pkg::OP_BYTE, sbpe_pkg::START_BYTE));
		send_item(make_op(sbpe_pkg::OP_TICK, 8'h00));
		send_item(make_op(OP_UNUSED, sbpe_pkg::START_BYTE));
	endtask

	// command while waiting, servo error byte, param byte order
	task automatic test_reply_parsing();
		send_item(make_cmd(8'd0, 8'h02, 3'd2, 48'h2B03, 2'd1));
		send_item(make_cmd(8'd1, 8'h03, 3'd6, 48'h0605_0403_0201, 2'd0));
		send_line_bytes(5, 96'({sbpe_pkg::START_BYTE, sbpe_pkg::START_BYTE, 8'd1,
			8'h08, 8'h24}));
	endtask

	// zero timeout: first tick ends the wait, also in the middle of a reply
	task automatic test_zero_timeout();
		set_timeout(16'd0);
		send_item(make_cmd(8'd2, 8'h01, 3'd0, 48'h0, 2'd0));
		send_ticks(1);
		send_item(make_cmd(8'd3, 8'h02, 3'd2, 48'h0224, 2'd2));
		send_line_bytes(1, 96'(sbpe_pkg::START_BYTE));
		send_ticks(1);
	endtask

	// output held off for a long stretch while commands keep coming
	task automatic test_output_backpressure();
		set_timeout(16'd4);
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = HOLD_CYCLES;
		repeat (8)
			send_item(random_cmd());
		wait_all_results();
	endtask

	task automatic test_random_traffic();
		set_timeout(16'd3);
		run_exchanges(22, 0, 0);
		set_timeout(16'd5);
		run_exchanges(22, 86, 0);
		set_timeout(16'd1);
		run_exchanges(22, 0, 86);
		// largest timeout, the waits below never run out
		set_timeout(16'hFFFF);
		run_exchanges(22, 28, 28);
	endtask

	// output side: random stall, forced low during a hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	// every accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		bus_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_bus_results.size() == 0) begin
				report_mismatch("unexpected result kind", 16'(res.kind), 16'h0);
			end else begin
				want = pending_bus_results.pop_front();
				check_field("kind", 16'(res.kind), 16'(want.kind));
				check_field("send_byte", 16'(res.send_byte), 16'(want.send_byte));
				check_field("last", 16'(res.last), 16'(want.last));
				check_field("status", 16'(res.status), 16'(want.status));
				check_field("error_flags", 16'(res.error_flags), 16'(want.error_flags));
				check_field("reply_value", res.reply_value, want.reply_value);
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = 3'd0;
		pwdata               = 32'h0;
		cmd.valid            = 1'b0;
		cmd.opcode           = sbpe_pkg::OP_SEND;
		cmd.servo_id         = 8'h00;
		cmd.instruction      = 8'h00;
		cmd.param_count      = 3'd0;
		cmd.param_bytes      = 48'h0;
		cmd.reply_data_count = 2'd0;
		cmd.line_byte        = 8'h00;
		res.ready            = 1'b0;
		timeout_ticks_cfg    = sbpe_pkg::TIMEOUT_RESET;
		awaiting_reply       = 1'b0;
		reply_phase          = PH_HUNT0;
		ticks_waited         = 0;
		reply_len            = 2'd0;
		data_lo              = 8'h00;
		mismatch_count       = 0;
		counted_items        = 0;
		send_idle_pct        = 0;
		stall_pct            = 0;
		hold_left            = 0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_packet_framing();
		test_reply_parsing();
		test_zero_timeout();
		test_output_backpressure();
		test_random_traffic();

		// anything still owed keeps this loop waiting until the time limit
		wait_all_results();
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hang guard
	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
